// File: hdl/sfr_pkg.sv
// Shared constants and types for the stream find-and-replace block.
package sfr_pkg;

  // Pattern and replacement capacity in bytes
  localparam int unsigned PAT_MAX    = 8;
  localparam int unsigned REP_MAX    = 8;
  // Held bytes never reach a full pattern
  localparam int unsigned PEND_DEPTH = PAT_MAX - 1;
  // Most results one transaction can cause
  localparam int unsigned BUF_DEPTH  = (PAT_MAX > REP_MAX) ? PAT_MAX : REP_MAX;

  localparam int unsigned LEN_W  = 4;
  localparam int unsigned PCNT_W = $clog2(PEND_DEPTH + 1);
  localparam int unsigned BCNT_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned BIDX_W = $clog2(BUF_DEPTH);
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LEN   = 8'd0,
    CFG_PAT_BYTES = 8'd1,
    CFG_REP_LEN   = 8'd2,
    CFG_REP_BYTES = 8'd3
  } cfg_reg_e;

  // Outcome of one input transaction, from the matcher to the top level
  typedef struct packed {
    logic [BCNT_W-1:0]              emit_cnt;
    logic                           bare;
    logic [BUF_DEPTH-1:0][7:0]      emit_bytes;
    logic                           pend_we;
    logic [PCNT_W-1:0]              pend_cnt;
    logic [PEND_DEPTH-1:0][7:0]     pend_bytes;
  } match_res_t;

endpackage

// File: hdl/sfr_match.sv
// Single-pass matcher: candidate run, prefix search, emitted bytes and next held run.
module sfr_match import sfr_pkg::*; (
  input  logic                        has_byte_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_i,
  input  logic [PCNT_W-1:0]           pend_cnt_i,
  input  logic [PEND_DEPTH-1:0][7:0]  pend_bytes_i,
  input  logic [LEN_W-1:0]            pat_len_i,
  input  logic [PAT_MAX-1:0][7:0]     pat_bytes_i,
  input  logic [LEN_W-1:0]            rep_len_i,
  input  logic [REP_MAX-1:0][7:0]     rep_bytes_i,
  output match_res_t                  res_o
);

  logic [LEN_W-1:0]          plen;
  logic [LEN_W-1:0]          rlen;
  logic [LEN_W-1:0]          m;
  logic [LEN_W-1:0]          start;
  logic [LEN_W-1:0]          keep;
  logic [PAT_MAX-1:0][7:0]   cand;
  logic [PAT_MAX-1:0]        head_ok;
  logic                      full;

  // Saturate configured lengths; a zero pattern length acts as one
  always_comb begin
    if (pat_len_i == '0) begin
      plen = LEN_W'(1);
    end else if (pat_len_i > LEN_W'(PAT_MAX)) begin
      plen = LEN_W'(PAT_MAX);
    end else begin
      plen = pat_len_i;
    end
    if (rep_len_i > LEN_W'(REP_MAX)) begin
      rlen = LEN_W'(REP_MAX);
    end else begin
      rlen = rep_len_i;
    end
  end

  // Candidate run: held bytes followed by the new byte
  always_comb begin
    m = LEN_W'(pend_cnt_i) + LEN_W'(has_byte_i);
    for (int i = 0; i < PEND_DEPTH; i++) begin
      cand[i] = (PCNT_W'(i) < pend_cnt_i) ? pend_bytes_i[i] : data_byte_i;
    end
    cand[PAT_MAX-1] = data_byte_i;
  end

  // Does the tail starting at each offset agree with the pattern head
  always_comb begin
    for (int s = 0; s < PAT_MAX; s++) begin
      head_ok[s] = 1'b1;
      for (int i = 0; i < PAT_MAX; i++) begin
        if (s + i < PAT_MAX) begin
          if ((LEN_W'(s + i) < m) && (cand[s + i] != pat_bytes_i[i])) begin
            head_ok[s] = 1'b0;
          end
        end
      end
    end
  end

  // Full match, else first offset that is still a strict prefix
  always_comb begin
    full  = has_byte_i && (m == plen) && head_ok[0];
    start = m;
    for (int s = PAT_MAX - 1; s >= 0; s--) begin
      if ((LEN_W'(s) < m) && ((m - LEN_W'(s)) < plen) && head_ok[s]) begin
        start = LEN_W'(s);
      end
    end
    keep = m - start;
  end

  // Results and next held run
  always_comb begin
    res_o = '0;
    if (has_byte_i) begin
      if (full) begin
        res_o.emit_cnt = BCNT_W'(rlen);
      end else if (end_i) begin
        res_o.emit_cnt = BCNT_W'(m);
      end else begin
        res_o.emit_cnt = BCNT_W'(start);
      end
    end else if (end_i) begin
      res_o.emit_cnt = BCNT_W'(m);
    end
    res_o.bare = end_i && (res_o.emit_cnt == '0);

    for (int j = 0; j < BUF_DEPTH; j++) begin
      if (full && (j < REP_MAX)) begin
        res_o.emit_bytes[j] = rep_bytes_i[j];
      end else if (j < PAT_MAX) begin
        res_o.emit_bytes[j] = cand[j];
      end else begin
        res_o.emit_bytes[j] = '0;
      end
    end

    res_o.pend_we = has_byte_i || end_i;
    if (end_i || full) begin
      res_o.pend_cnt = '0;
    end else begin
      res_o.pend_cnt = PCNT_W'(keep);
    end
    for (int i = 0; i < PEND_DEPTH; i++) begin
      res_o.pend_bytes[i] = cand[PAT_MAX-1];
      for (int s = 0; s < PAT_MAX; s++) begin
        if ((s + i < PAT_MAX) && (start == LEN_W'(s))) begin
          res_o.pend_bytes[i] = cand[s + i];
        end
      end
    end
  end

endmodule

// File: hdl/stream_find_replace_unit.sv
// Top level of the streaming find-and-replace block.
//
// Input stream (s_axis_*): one string byte per transaction. tdata is the byte,
// tuser says whether tdata carries a byte (0 = bare end marker), tlast ends the
// string. Output stream (m_axis_*): the rewritten string, same field layout.
// Configuration channel (cfg_*): index 0 pattern length, 1 pattern bytes,
// 2 replacement length, 3 replacement bytes; other indexes are ignored.
// Write it only while the block is idle; cfg_ready_o is always high.
//
// Each input transaction is matched against the held bytes and loads up to
// eight results into an output buffer; the first result shows in the cycle
// after acceptance. While the receiver is ready the buffer drains one result
// per cycle, so an input that causes zero or one result sustains one
// transaction per cycle, and one that causes more holds off the input.
// When the receiver stalls the buffer holds its result and the input is taken
// only as the last buffered result leaves.
// Reset clears the held bytes and the output buffer and restores pattern
// length 1, pattern and replacement 0, replacement length 0.
module stream_find_replace_unit import sfr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] has_byte
  input  logic                   s_axis_tlast,
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
  output logic                   m_axis_tuser,   // [0] out_has_byte
  output logic                   m_axis_tlast,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [LEN_W-1:0]            pat_len_q;
  logic [PAT_MAX-1:0][7:0]     pat_bytes_q;
  logic [LEN_W-1:0]            rep_len_q;
  logic [REP_MAX-1:0][7:0]     rep_bytes_q;

  logic [PCNT_W-1:0]           pend_cnt_q, pend_cnt_d;
  logic [PEND_DEPTH-1:0][7:0]  pend_bytes_q, pend_bytes_d;

  logic [BCNT_W-1:0]           out_cnt_q, out_cnt_d;
  logic [BIDX_W-1:0]           out_idx_q, out_idx_d;
  logic [BUF_DEPTH-1:0][7:0]   out_bytes_q, out_bytes_d;
  logic                        out_has_q, out_has_d;
  logic                        out_last_q, out_last_d;

  logic                        in_fire;
  logic                        out_fire;
  match_res_t                  res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= LEN_W'(1);
      pat_bytes_q <= '0;
      rep_len_q   <= '0;
      rep_bytes_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PAT_LEN:   pat_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_PAT_BYTES: pat_bytes_q <= cfg_data_i[PAT_MAX*8-1:0];
        CFG_REP_LEN:   rep_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_REP_BYTES: rep_bytes_q <= cfg_data_i[REP_MAX*8-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes: take input when the buffer is empty or empties this cycle
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (out_cnt_q == '0) || ((out_cnt_q == BCNT_W'(1)) && m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  sfr_match u_match (
    .has_byte_i   (s_axis_tuser),
    .data_byte_i  (s_axis_tdata),
    .end_i        (s_axis_tlast),
    .pend_cnt_i   (pend_cnt_q),
    .pend_bytes_i (pend_bytes_q),
    .pat_len_i    (pat_len_q),
    .pat_bytes_i  (pat_bytes_q),
    .rep_len_i    (rep_len_q),
    .rep_bytes_i  (rep_bytes_q),
    .res_o        (res)
  );

  // Held run update
  always_comb begin
    pend_cnt_d   = pend_cnt_q;
    pend_bytes_d = pend_bytes_q;
    if (in_fire && res.pend_we) begin
      pend_cnt_d   = res.pend_cnt;
      pend_bytes_d = res.pend_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= '0;
    end else begin
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_bytes_q <= pend_bytes_d;
  end

  // Output buffer: load a burst on input, drain one result per transaction
  always_comb begin
    out_cnt_d   = out_cnt_q;
    out_idx_d   = out_idx_q;
    out_bytes_d = out_bytes_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    if (in_fire) begin
      out_cnt_d   = res.bare ? BCNT_W'(1) : res.emit_cnt;
      out_idx_d   = '0;
      out_bytes_d = res.emit_bytes;
      out_has_d   = !res.bare;
      out_last_d  = s_axis_tlast;
    end else if (out_fire) begin
      out_cnt_d = out_cnt_q - BCNT_W'(1);
      out_idx_d = out_idx_q + BIDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q  <= '0;
      out_idx_q  <= '0;
      out_has_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      out_cnt_q  <= out_cnt_d;
      out_idx_q  <= out_idx_d;
      out_has_q  <= out_has_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bytes_q <= out_bytes_d;
  end

  // Output stream
  assign m_axis_tvalid = (out_cnt_q != '0);
  assign m_axis_tdata  = out_has_q ? out_bytes_q[out_idx_q] : 8'h00;
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_last_q && (out_cnt_q == BCNT_W'(1));

endmodule

// File: test/stream_find_replace_unit_tb.sv
// Self-checking testbench for the streaming find-and-replace block.
module stream_find_replace_unit_tb;
  import sfr_pkg::*;

  // One rewritten output transaction
  typedef struct packed {
    logic       has;
    logic [7:0] data;
    logic       last;
  } rewritten_t;

  // Tracks configuration and held bytes, predicts the rewritten stream
  class find_replace_sb;
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] pat_word;
    logic [LEN_W-1:0]      rep_len;
    logic [CFG_DATA_W-1:0] rep_word;
    logic [7:0]            held [PEND_DEPTH];
    int                    held_cnt;
    logic [7:0]            cand [PAT_MAX+1];
    rewritten_t            rewritten_q [$];
    int                    errors;

    function new();
      pat_len  = 1;
      pat_word = '0;
      rep_len  = 0;
      rep_word = '0;
      held_cnt = 0;
      errors   = 0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PAT_LEN:   pat_len  = val[LEN_W-1:0];
        CFG_PAT_BYTES: pat_word = val;
        CFG_REP_LEN:   rep_len  = val[LEN_W-1:0];
        CFG_REP_BYTES: rep_word = val;
        default: ;
      endcase
    endfunction

    // Zero acts as one, large values saturate
    function int pat_len_eff();
      if (pat_len == 0) return 1;
      if (pat_len > PAT_MAX) return PAT_MAX;
      return int'(pat_len);
    endfunction

    function int rep_len_eff();
      if (rep_len > REP_MAX) return REP_MAX;
      return int'(rep_len);
    endfunction

    function logic [7:0] pat_byte(int i);
      return pat_word[8*i +: 8];
    endfunction

    // Candidate bytes from off on equal the pattern head of length len
    function bit head_match(int off, int len);
      int i;
      for (i = 0; i < len; i++)
        if (cand[off+i] != pat_byte(i)) return 1'b0;
      return 1'b1;
    endfunction

    function void push(logic has, logic [7:0] b);
      rewritten_t r;
      r.has  = has;
      r.data = b;
      r.last = 1'b0;
      rewritten_q.push_back(r);
    endfunction

    // Accepted input transaction: update held bytes, queue expected output
    function void take_input(logic has, logic [7:0] b, logic eos);
      int n, start, plen, made, i;
      rewritten_t r;
      plen = pat_len_eff();
      n    = held_cnt;
      made = rewritten_q.size();
      for (i = 0; i < n; i++) cand[i] = held[i];
      if (has) begin
        cand[n] = b;
        n++;
        start = 0;
        if (n == plen && head_match(0, n)) begin
          for (i = 0; i < rep_len_eff(); i++) push(1'b1, rep_word[8*i +: 8]);
          start = n;
        end else begin
          // release bytes until the tail is a strict pattern prefix
          while (start < n && !((n - start) < plen && head_match(start, n - start))) begin
            push(1'b1, cand[start]);
            start++;
          end
        end
        held_cnt = n - start;
        for (i = 0; i < held_cnt; i++) held[i] = cand[start+i];
      end
      if (eos) begin
        for (i = 0; i < held_cnt; i++) push(1'b1, held[i]);
        held_cnt = 0;
        // bare end marker when nothing else came out of this transaction
        if (rewritten_q.size() == made) push(1'b0, 8'h00);
        r = rewritten_q.pop_back();
        r.last = 1'b1;
        rewritten_q.push_back(r);
      end
    endfunction

    task report(string msg);
      // print is capped so a broken build does not flood the log
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_output(logic has, logic [7:0] b, logic last);
      rewritten_t e;
      if (rewritten_q.size() == 0) begin
        report($sformatf("unexpected result has=%0b byte=%02h last=%0b", has, b, last));
        return;
      end
      e = rewritten_q.pop_front();
      if (has !== e.has)
        report($sformatf("has_byte got %0b want %0b", has, e.has));
      if (b !== e.data)
        report($sformatf("byte got %02h want %02h", b, e.data));
      if (last !== e.last)
        report($sformatf("last got %0b want %0b (byte %02h)", last, e.last, e.data));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'h00;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  find_replace_sb sb;
  int   items_sent   = 0;
  bit   tx_free      = 1'b0;
  bit   rx_free      = 1'b0;
  int   rx_hold_left = 0;
  logic [7:0] alpha [3];

  stream_find_replace_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Monitor both streams at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_output(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.take_input(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    end
  end

  // Receiver: long hold-off first, then free running or random runs
  initial begin
    bit rx_ready_now;
    int rx_run_left;
    rx_ready_now = 1'b1;
    rx_run_left  = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (rx_free) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (rx_run_left == 0) begin
          rx_ready_now = !rx_ready_now;
          rx_run_left  = rx_ready_now ? $urandom_range(1, 30) : stall_len();
        end
        m_axis_tready <= rx_ready_now;
        rx_run_left--;
      end
    end
  end

  // One input transaction; valid stays high when the next one follows at once
  task automatic send_item(logic has, logic [7:0] b, logic eos);
    int gap;
    gap = tx_free ? 0 : pick_gap();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= has;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    if (has || eos) items_sent++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic tx_release();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pause until every expected result is out
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.rewritten_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure_phase();
    logic [CFG_DATA_W-1:0] w;
    logic [LEN_W-1:0]      len;
    int i;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
    // pattern length, sometimes out of range
    if ($urandom_range(0, 99) < 85) len = LEN_W'($urandom_range(1, PAT_MAX));
    else len = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(PAT_MAX + 1, 15));
    cfg_write(CFG_PAT_LEN, CFG_DATA_W'(len));
    // pattern from a small alphabet so prefixes overlap, or fully random
    w = {$urandom, $urandom};
    if ($urandom_range(0, 4) != 0)
      for (i = 0; i < PAT_MAX; i++)
        w[8*i +: 8] = ($urandom_range(0, 3) != 0) ? alpha[$urandom_range(0, 1)] : alpha[2];
    cfg_write(CFG_PAT_BYTES, w);
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 99) < 85) len = LEN_W'($urandom_range(0, REP_MAX));
      else len = 4'($urandom_range(REP_MAX + 1, 15));
      cfg_write(CFG_REP_LEN, CFG_DATA_W'(len));
      cfg_write(CFG_REP_BYTES, {$urandom, $urandom});
    end
    // index past the register list is ignored
    if ($urandom_range(0, 5) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(CFG_REP_BYTES + 1, 255)), {$urandom, $urandom});
  endtask

  // Strings built from pattern copies, prefixes and noise
  task automatic send_phase(int n);
    int start, seg, plen, len, i;
    start = items_sent;
    while (items_sent - start < n) begin
      plen = sb.pat_len_eff();
      seg  = $urandom_range(0, 99);
      if (seg < 30) begin
        for (i = 0; i < plen; i++) send_item(1'b1, sb.pat_byte(i), 1'b0);
      end else if (seg < 52) begin
        len = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
        for (i = 0; i < len; i++) send_item(1'b1, sb.pat_byte(i), 1'b0);
      end else if (seg < 75) begin
        send_item(1'b1, alpha[$urandom_range(0, 2)], 1'b0);
      end else if (seg < 86) begin
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
      end else if (seg < 96) begin
        // end of string: on a byte, or a bare marker
        if ($urandom_range(0, 4) != 0)
          send_item(1'b1, ($urandom_range(0, 1) != 0) ? alpha[$urandom_range(0, 2)]
                                                        : 8'($urandom_range(0, 255)), 1'b1);
        else
          send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // neither byte nor end: ignored by the block
        send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    int p;
    logic [CFG_DATA_W-1:0] w;
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: one-byte pattern 00 is deleted
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'h5A, 1'b0);
    send_item(1'b0, 8'hA5, 1'b1);
    send_item(1'b1, 8'h00, 1'b1);
    tx_release();
    wait_drained();
    cfg_write(CFG_IDX_W'(200), {$urandom, $urandom});

    // Three-byte pattern, two-byte replacement, garbage in unused bytes
    w = {$urandom, $urandom};
    w[23:0] = 24'h636261;
    cfg_write(CFG_PAT_LEN, 64'd3);
    cfg_write(CFG_PAT_BYTES, w);
    w = {$urandom, $urandom};
    w[15:0] = 16'h5958;
    cfg_write(CFG_REP_LEN, 64'd2);
    cfg_write(CFG_REP_BYTES, w);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    send_item(1'b1, 8'h78, 1'b0);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    send_item(1'b1, 8'h63, 1'b0);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    send_item(1'b1, 8'h63, 1'b0);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    tx_release();
    wait_drained();

    // Pattern changed while bytes are held; length zero acts as one
    w = {$urandom, $urandom};
    w[7:0] = 8'h62;
    cfg_write(CFG_PAT_LEN, 64'd0);
    cfg_write(CFG_PAT_BYTES, w);
    send_item(1'b1, 8'h7A, 1'b1);
    tx_release();
    wait_drained();

    // Saturated lengths: eight-byte all-ones pattern, eight-byte replacement
    cfg_write(CFG_PAT_LEN, 64'd15);
    cfg_write(CFG_PAT_BYTES, '1);
    cfg_write(CFG_REP_LEN, 64'd15);
    cfg_write(CFG_REP_BYTES, {$urandom, $urandom});
    repeat (7) send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b1, 8'hFF, 1'b1);
    tx_release();

    // Random phases; strings may stay open across a reconfiguration
    p = 0;
    while (items_sent < 430) begin
      wait_drained();
      configure_phase();
      tx_free = (p == 2 || p == 4);
      rx_free = (p == 4);
      if (p == 2) rx_hold_left = 300;
      send_phase($urandom_range(25, 50));
      tx_release();
      tx_free = 1'b0;
      rx_free = 1'b0;
      p++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.rewritten_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.rewritten_q.size()));
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
hdl/sfr_pkg.sv
hdl/sfr_match.sv
hdl/stream_find_replace_unit.sv
test/stream_find_replace_unit_tb.sv
